FILE: src/lrdc_pkg.sv
// Package for the load request dedup and outcome cache.
// Holds the item structs, op and status codes; used by every module in src.
`default_nettype none
package lrdc_pkg;
    localparam logic [1:0] OP_REQUEST    = 2'd0;
    localparam logic [1:0] OP_TAKE_NEXT  = 2'd1;
    localparam logic [1:0] OP_COMPLETE   = 2'd2;
    localparam logic [1:0] OP_INVALIDATE = 2'd3;

    localparam logic [2:0] ST_QUEUED      = 3'd0;
    localparam logic [2:0] ST_PENDING     = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_MISSING     = 3'd3;
    localparam logic [2:0] ST_FAILED      = 3'd4;
    localparam logic [2:0] ST_UNAVAILABLE = 3'd5;

    localparam logic [15:0] RETRY_DELAY_RESET = 16'd2000;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] night_start;
        logic [63:0] tag;
        logic [1:0]  req_mask;
        logic [31:0] now_ms;
        logic [1:0]  checked_in;
        logic [1:0]  available_in;
        logic [1:0]  failed_in;
        logic        clear_all;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  request_status;
        logic        started;
        logic [63:0] start_night;
        logic [63:0] start_tag;
        logic        busy_res;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item, clear scan state
        logic tbl_step;   // examine table entry at the table index
        logic q_step;     // examine queue entry at the queue index
        logic finish;     // apply the decided update, build the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tbl_last;   // table index is at the last entry
        logic q_last;     // queue index is at the last entry
        logic tbl_done;   // table scan already decided
    } t_sts;
endpackage
`default_nettype wire

FILE: src/lrdc_ctrl.sv
// Controller for the load request dedup and outcome cache.
// Sequences the table and queue scans; uses lrdc_pkg.
`default_nettype none
module lrdc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_out_busy,
    input  wire lrdc_pkg::t_sts    i_sts,
    output lrdc_pkg::t_cmd         o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_TBL, S_QUE, S_FIN} t_state;
    t_state r_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.tbl_step = (r_state == S_TBL);
        o_cmd.q_step   = (r_state == S_QUE);
        o_cmd.finish   = (r_state == S_FIN) && !i_out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_TBL;
                S_TBL:  if (i_sts.tbl_last || i_sts.tbl_done) r_state <= S_QUE;
                S_QUE:  if (i_sts.q_last) r_state <= S_FIN;
                S_FIN:  if (!i_out_busy) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/lrdc_dp.sv
// Datapath for the load request dedup and outcome cache: outcome table,
// queue, active slot and result register. Uses lrdc_pkg.
`default_nettype none
module lrdc_dp #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lrdc_pkg::t_in_item  i_item,
    input  wire logic [15:0]         i_retry_delay,
    input  wire lrdc_pkg::t_cmd      i_cmd,
    output lrdc_pkg::t_sts           o_sts,
    output lrdc_pkg::t_out_item      o_res,
    output logic                     o_res_valid,
    input  wire logic                i_res_take
);
    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [TW-1:0] T_LAST = TW'(TABLE_ENTRIES - 1);
    localparam logic [QW-1:0] Q_LAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] Q_FULL = FW'(QUEUE_DEPTH);

    lrdc_pkg::t_in_item r_it;

    logic [TABLE_ENTRIES-1:0] r_ev;
    logic [63:0] r_en [TABLE_ENTRIES];
    logic [63:0] r_et [TABLE_ENTRIES];
    logic [5:0]  r_em [TABLE_ENTRIES];
    logic [31:0] r_er [TABLE_ENTRIES];
    logic [31:0] r_eu [TABLE_ENTRIES];
    logic [31:0] r_use;

    logic [63:0] r_qn [QUEUE_DEPTH];
    logic [63:0] r_qt [QUEUE_DEPTH];
    logic [FW-1:0] r_fill;
    logic        r_act;
    logic [63:0] r_an, r_at;

    logic [TW-1:0] r_ti;
    logic [QW-1:0] r_qi;
    // Table scan results.
    logic          r_tdone;   // first match found (request or complete)
    logic          r_tmatch;
    logic          r_tfree;   // a free entry seen
    logic [TW-1:0] r_tfree_i;
    logic [TW-1:0] r_lru_i;
    logic [31:0]   r_lru_u;
    logic [TW-1:0] r_hit_i;
    logic [2:0]    r_tans;    // table answer, ST_QUEUED meaning none
    // Queue scan results.
    logic          r_qdup;
    logic [QW-1:0] r_wr;      // compaction write pointer
    logic [FW-1:0] r_keep;

    logic [63:0] k_n, k_t;
    logic        e_hit, e_keyn;
    logic [1:0]  f_chk, f_avl, f_fl;
    logic [31:0] tdiff;
    logic        q_in;

    always_comb begin
        k_n = (r_it.op == lrdc_pkg::OP_COMPLETE) ? r_an : r_it.night_start;
        k_t = (r_it.op == lrdc_pkg::OP_COMPLETE) ? r_at : r_it.tag;
        e_keyn = r_ev[r_ti] && (r_en[r_ti] == r_it.night_start);
        e_hit  = r_ev[r_ti] && (r_en[r_ti] == k_n) && (r_et[r_ti] == k_t);
        f_chk = r_em[r_ti][1:0] & r_it.req_mask;
        f_avl = r_em[r_ti][3:2] & r_it.req_mask;
        f_fl  = r_em[r_ti][5:4] & r_it.req_mask;
        tdiff = r_it.now_ms - r_er[r_ti];
        q_in  = {1'b0, r_qi} < (QW+1)'(r_fill);
    end

    assign o_sts.tbl_last = (r_ti == T_LAST);
    assign o_sts.q_last   = (r_qi == Q_LAST);
    assign o_sts.tbl_done = r_tdone;

    logic          valid_key;
    logic [2:0]    req_st;
    logic [TW-1:0] pick;
    always_comb begin
        valid_key = (r_it.night_start != '0) && (r_it.tag != '0);
        if (!valid_key) req_st = lrdc_pkg::ST_UNAVAILABLE;
        else if (r_tans != lrdc_pkg::ST_QUEUED) req_st = r_tans;
        else if ((r_act && r_an == r_it.night_start && r_at == r_it.tag) || r_qdup)
            req_st = lrdc_pkg::ST_PENDING;
        else if (r_fill >= Q_FULL) req_st = lrdc_pkg::ST_FULL;
        else req_st = lrdc_pkg::ST_QUEUED;
        if (r_tmatch) pick = r_hit_i;
        else if (r_tfree) pick = r_tfree_i;
        else pick = r_lru_i;
    end

    // Result item built from the state before the commit.
    lrdc_pkg::t_out_item n_res;
    always_comb begin
        n_res = '0;
        case (r_it.op)
            lrdc_pkg::OP_REQUEST: begin
                n_res.request_status = req_st;
                n_res.busy_res = r_act || (r_fill != '0)
                    || (req_st == lrdc_pkg::ST_QUEUED);
            end
            lrdc_pkg::OP_TAKE_NEXT: begin
                if (!r_act && r_fill != '0) begin
                    n_res.started = 1'b1;
                    n_res.start_night = r_qn[0];
                    n_res.start_tag = r_qt[0];
                    n_res.busy_res = 1'b1;
                end else begin
                    n_res.busy_res = r_act || (r_fill != '0);
                end
            end
            lrdc_pkg::OP_COMPLETE: begin
                n_res.busy_res = (r_fill != '0);
            end
            default: begin
                n_res.busy_res = r_act || (r_keep != '0);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
            r_use <= '0;
            r_fill <= '0;
            r_act <= 1'b0;
            r_an <= '0;
            r_at <= '0;
            o_res_valid <= 1'b0;
            r_ti <= '0;
            r_qi <= '0;
        end else begin
            if (i_cmd.finish) o_res_valid <= 1'b1;
            else if (i_res_take) o_res_valid <= 1'b0;
            if (i_cmd.load) begin
                r_it <= i_item;
                r_ti <= '0;
                r_qi <= '0;
                r_tdone <= 1'b0;
                r_tmatch <= 1'b0;
                r_tfree <= 1'b0;
                r_lru_i <= '0;
                r_tans <= lrdc_pkg::ST_QUEUED;
                r_qdup <= 1'b0;
                r_wr <= '0;
                r_keep <= '0;
            end
            if (i_cmd.tbl_step) begin
                if (r_ti != T_LAST) r_ti <= r_ti + 1'b1;
                unique case (r_it.op)
                    lrdc_pkg::OP_REQUEST: begin
                        if (!r_tdone && e_hit && valid_key) begin
                            r_tdone <= 1'b1;
                            r_use <= r_use + 1'b1;
                            r_eu[r_ti] <= r_use + 1'b1;
                            if (f_fl != '0 && tdiff[31])
                                r_tans <= lrdc_pkg::ST_FAILED;
                            else if (f_chk != '0 && f_avl == '0 && f_fl == '0)
                                r_tans <= lrdc_pkg::ST_MISSING;
                        end
                    end
                    lrdc_pkg::OP_COMPLETE: begin
                        if (!r_tdone) begin
                            if (e_hit) begin
                                r_tdone <= 1'b1;
                                r_tmatch <= 1'b1;
                                r_hit_i <= r_ti;
                            end
                            if (!r_ev[r_ti] && !r_tfree) begin
                                r_tfree <= 1'b1;
                                r_tfree_i <= r_ti;
                            end
                            if (r_ti == '0 || r_eu[r_ti] < r_lru_u) begin
                                r_lru_i <= r_ti;
                                r_lru_u <= r_eu[r_ti];
                            end
                        end
                    end
                    lrdc_pkg::OP_INVALIDATE: begin
                        if (r_ev[r_ti] && (r_it.clear_all || e_keyn)) begin
                            r_ev[r_ti] <= 1'b0;
                            r_eu[r_ti] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.q_step) begin
                if (r_qi != Q_LAST) r_qi <= r_qi + 1'b1;
                case (r_it.op)
                    lrdc_pkg::OP_REQUEST: begin
                        if (q_in && r_qn[r_qi] == r_it.night_start
                            && r_qt[r_qi] == r_it.tag)
                            r_qdup <= 1'b1;
                    end
                    lrdc_pkg::OP_INVALIDATE: begin
                        // Compact survivors toward the head, one entry a cycle.
                        if (q_in && !r_it.clear_all && r_qn[r_qi] != r_it.night_start)
                        begin
                            r_qn[r_wr] <= r_qn[r_qi];
                            r_qt[r_wr] <= r_qt[r_qi];
                            r_wr <= r_wr + 1'b1;
                            r_keep <= r_keep + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                o_res <= n_res;
                unique case (r_it.op)
                    lrdc_pkg::OP_REQUEST: begin
                        if (req_st == lrdc_pkg::ST_QUEUED) begin
                            r_qn[r_fill[QW-1:0]] <= r_it.night_start;
                            r_qt[r_fill[QW-1:0]] <= r_it.tag;
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                    lrdc_pkg::OP_TAKE_NEXT: begin
                        if (!r_act && r_fill != '0) begin
                            r_act <= 1'b1;
                            r_an <= r_qn[0];
                            r_at <= r_qt[0];
                            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                                r_qn[i-1] <= r_qn[i];
                                r_qt[i-1] <= r_qt[i];
                            end
                            r_fill <= r_fill - 1'b1;
                        end
                    end
                    lrdc_pkg::OP_COMPLETE: begin
                        if (r_act) begin
                            r_ev[pick] <= 1'b1;
                            r_en[pick] <= r_an;
                            r_et[pick] <= r_at;
                            r_em[pick] <= {r_it.failed_in, r_it.available_in,
                                           r_it.checked_in};
                            r_er[pick] <= (r_it.failed_in != '0)
                                ? r_it.now_ms + {16'd0, i_retry_delay} : '0;
                            r_use <= r_use + 1'b1;
                            r_eu[pick] <= r_use + 1'b1;
                            r_act <= 1'b0;
                            r_an <= '0;
                            r_at <= '0;
                        end
                    end
                    lrdc_pkg::OP_INVALIDATE: begin
                        r_fill <= r_keep;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/load_request_dedup_and_outcome_cache.sv
// Load request filter: each item (request, take next, complete, invalidate)
// yields one result item. The item is taken in, the outcome table is walked one
// entry a cycle, the queue one entry a cycle, then the update is committed and
// the result item registered. A request or complete that finds its key in the
// table leaves the table walk early once the hit is registered, and the commit
// waits while a result is stalled at the output. One item is in flight at a
// time; the result register lets the next item enter while a result waits.
// The retry delay register is written with i_cfg_we.
`default_nettype none
module load_request_dedup_and_outcome_cache #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lrdc_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lrdc_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [15:0]         i_cfg_data
);
    logic [15:0]    r_retry;
    lrdc_pkg::t_cmd cmd;
    lrdc_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_retry <= lrdc_pkg::RETRY_DELAY_RESET;
        else if (i_cfg_we) r_retry <= i_cfg_data;
    end

    lrdc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_out_busy(o_out_valid && i_out_stall),
        .i_sts(sts), .o_cmd(cmd)
    );

    lrdc_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in_data),
        .i_retry_delay(r_retry), .i_cmd(cmd), .o_sts(sts),
        .o_res(o_out_data), .o_res_valid(o_out_valid),
        .i_res_take(o_out_valid && !i_out_stall)
    );
endmodule
`default_nettype wire

FILE: sim/tb_load_request_dedup_and_outcome_cache.sv
// Testbench for the load request dedup and outcome cache.
// Drives items over the valid/stall channel, predicts every result item from its own
// model of the table and queue, and checks field by field; depends on src/lrdc_pkg.sv.
`timescale 1ns / 100ps
`default_nettype none
module tb_load_request_dedup_and_outcome_cache;
    localparam int QDEPTH   = 8;
    localparam int TENTRIES = 8;
    localparam int LATENCY  = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    lrdc_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    lrdc_pkg::t_out_item o_out_data;
    logic                i_cfg_we;
    logic [15:0]         i_cfg_data;

    load_request_dedup_and_outcome_cache i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state.
    logic [15:0] retry_delay;
    logic [63:0] q_night [QDEPTH];
    logic [63:0] q_tag   [QDEPTH];
    int          q_fill;
    logic        act_flag;
    logic [63:0] act_night;
    logic [63:0] act_tag;
    logic        e_valid [TENTRIES];
    logic [63:0] e_night [TENTRIES];
    logic [63:0] e_tag   [TENTRIES];
    logic [5:0]  e_masks [TENTRIES];
    logic [31:0] e_retry [TENTRIES];
    logic [31:0] e_use   [TENTRIES];
    logic [31:0] use_ctr;

    lrdc_pkg::t_out_item expected_results[$];
    int          fail_count = 0;
    int          row_fail_count;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    bit          hold_receiver;
    int          hold_cycles = 0;

    // Small key pools so that dedup and table hits happen often.
    logic [63:0] night_pool[4];
    logic [63:0] tag_pool[4];

    function automatic logic [2:0] lookup_request(logic [63:0] night, logic [63:0] tag,
                                                  logic [1:0] mask, logic [31:0] now);
        logic [1:0]  chk;
        logic [1:0]  avl;
        logic [1:0]  fl;
        logic [31:0] diff;
        if (night == '0 || tag == '0)
            return lrdc_pkg::ST_UNAVAILABLE;
        for (int i = 0; i < TENTRIES; i++) begin
            if (!e_valid[i] || e_night[i] != night || e_tag[i] != tag)
                continue;
            use_ctr = use_ctr + 32'd1;
            e_use[i] = use_ctr;
            chk = e_masks[i][1:0];
            avl = e_masks[i][3:2];
            fl = e_masks[i][5:4];
            diff = now - e_retry[i];
            if ((fl & mask) != '0 && diff[31])
                return lrdc_pkg::ST_FAILED;
            if ((chk & mask) != '0 && (avl & mask) == '0 && (fl & mask) == '0)
                return lrdc_pkg::ST_MISSING;
            break;
        end
        if (act_flag && act_night == night && act_tag == tag)
            return lrdc_pkg::ST_PENDING;
        for (int i = 0; i < q_fill; i++)
            if (q_night[i] == night && q_tag[i] == tag)
                return lrdc_pkg::ST_PENDING;
        if (q_fill >= QDEPTH)
            return lrdc_pkg::ST_FULL;
        q_night[q_fill] = night;
        q_tag[q_fill] = tag;
        q_fill++;
        return lrdc_pkg::ST_QUEUED;
    endfunction

    function automatic void record_outcome(lrdc_pkg::t_in_item it);
        int pick;
        bit found;
        pick = 0;
        found = 1'b0;
        if (!act_flag)
            return;
        for (int i = 0; i < TENTRIES; i++)
            if (!found && e_valid[i] && e_night[i] == act_night && e_tag[i] == act_tag) begin
                pick = i;
                found = 1'b1;
            end
        if (!found) begin
            for (int i = 0; i < TENTRIES; i++) begin
                if (!e_valid[i]) begin
                    pick = i;
                    break;
                end
                if (e_use[i] < e_use[pick])
                    pick = i;
            end
        end
        e_valid[pick] = 1'b1;
        e_night[pick] = act_night;
        e_tag[pick] = act_tag;
        e_masks[pick] = {it.failed_in, it.available_in, it.checked_in};
        e_retry[pick] = (it.failed_in != '0) ? it.now_ms + {16'd0, retry_delay} : 32'd0;
        use_ctr = use_ctr + 32'd1;
        e_use[pick] = use_ctr;
        act_flag = 1'b0;
        act_night = '0;
        act_tag = '0;
    endfunction

    function automatic void drop_night(logic [63:0] night, logic all);
        int w;
        w = 0;
        for (int i = 0; i < TENTRIES; i++)
            if (e_valid[i] && (all || e_night[i] == night)) begin
                e_valid[i] = 1'b0;
                e_night[i] = '0;
                e_tag[i] = '0;
                e_masks[i] = '0;
                e_retry[i] = '0;
                e_use[i] = '0;
            end
        for (int i = 0; i < q_fill; i++) begin
            if (all || q_night[i] == night)
                continue;
            q_night[w] = q_night[i];
            q_tag[w] = q_tag[i];
            w++;
        end
        for (int i = w; i < QDEPTH; i++) begin
            q_night[i] = '0;
            q_tag[i] = '0;
        end
        q_fill = w;
    endfunction

    function automatic lrdc_pkg::t_out_item predict_result(lrdc_pkg::t_in_item it);
        lrdc_pkg::t_out_item r;
        r = '0;
        case (it.op)
            lrdc_pkg::OP_REQUEST: begin
                r.request_status = lookup_request(it.night_start, it.tag, it.req_mask,
                                                  it.now_ms);
            end
            lrdc_pkg::OP_TAKE_NEXT: begin
                if (!act_flag && q_fill > 0) begin
                    act_flag = 1'b1;
                    act_night = q_night[0];
                    act_tag = q_tag[0];
                    for (int i = 1; i < q_fill; i++) begin
                        q_night[i-1] = q_night[i];
                        q_tag[i-1] = q_tag[i];
                    end
                    q_fill--;
                    q_night[q_fill] = '0;
                    q_tag[q_fill] = '0;
                    r.started = 1'b1;
                    r.start_night = act_night;
                    r.start_tag = act_tag;
                end
            end
            lrdc_pkg::OP_COMPLETE: record_outcome(it);
            default: drop_night(it.night_start, it.clear_all);
        endcase
        r.busy_res = act_flag || q_fill > 0;
        return r;
    endfunction

    function automatic void reset_predictor();
        retry_delay = lrdc_pkg::RETRY_DELAY_RESET;
        q_fill = 0;
        act_flag = 1'b0;
        act_night = '0;
        act_tag = '0;
        use_ctr = '0;
        for (int i = 0; i < QDEPTH; i++) begin
            q_night[i] = '0;
            q_tag[i] = '0;
        end
        for (int i = 0; i < TENTRIES; i++) begin
            e_valid[i] = 1'b0;
            e_night[i] = '0;
            e_tag[i] = '0;
            e_masks[i] = '0;
            e_retry[i] = '0;
            e_use[i] = '0;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stall, or a long forced hold-off.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (hold_receiver) begin
            hold_cycles <= 300;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Output checker.
    always @(posedge i_clk) begin
        lrdc_pkg::t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result item %p", $realtime, o_out_data);
                fail_count++;
            end else begin
                exp_item = expected_results.pop_front();
                if (o_out_data.request_status !== exp_item.request_status) begin
                    $display("%0t: request_status expected %0d actual %0d", $realtime,
                             exp_item.request_status, o_out_data.request_status);
                    fail_count++;
                end
                if (o_out_data.started !== exp_item.started) begin
                    $display("%0t: started expected %0d actual %0d", $realtime,
                             exp_item.started, o_out_data.started);
                    fail_count++;
                end
                if (o_out_data.start_night !== exp_item.start_night) begin
                    $display("%0t: start_night expected %h actual %h", $realtime,
                             exp_item.start_night, o_out_data.start_night);
                    fail_count++;
                end
                if (o_out_data.start_tag !== exp_item.start_tag) begin
                    $display("%0t: start_tag expected %h actual %h", $realtime,
                             exp_item.start_tag, o_out_data.start_tag);
                    fail_count++;
                end
                if (o_out_data.busy_res !== exp_item.busy_res) begin
                    $display("%0t: busy_res expected %0d actual %0d", $realtime,
                             exp_item.busy_res, o_out_data.busy_res);
                    fail_count++;
                end
            end
        end
    end

    // Offer one item and hold it until accepted.
    task automatic send_item(lrdc_pkg::t_in_item it, bit has_fixed,
                             lrdc_pkg::t_out_item fixed);
        lrdc_pkg::t_out_item predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = predict_result(it);
        if (has_fixed && predicted !== fixed) begin
            $display("%0t: table row expected %p predictor %p", $realtime, fixed, predicted);
            row_fail_count++;
        end
        expected_results.push_back(predicted);
    endtask

    task automatic drain_and_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_retry_delay(logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        retry_delay = value;
    endtask

    function automatic lrdc_pkg::t_in_item random_item(bit well_formed);
        lrdc_pkg::t_in_item it;
        it = '0;
        it.op = 2'($urandom_range(3));
        if (well_formed && it.op == lrdc_pkg::OP_INVALIDATE && $urandom_range(3) != 0)
            it.op = lrdc_pkg::OP_REQUEST;
        if ($urandom_range(9) == 0) begin
            it.night_start = {$urandom, $urandom};
            it.tag = {$urandom, $urandom};
            if ($urandom_range(3) == 0)
                it.tag = '0;
        end else begin
            it.night_start = night_pool[$urandom_range(3)];
            it.tag = tag_pool[$urandom_range(3)];
        end
        it.req_mask = 2'($urandom_range(3));
        it.now_ms = ($urandom_range(7) == 0) ? $urandom
                                             : 32'hFFFF_F000 + $urandom_range(8191);
        it.checked_in = 2'($urandom_range(3));
        it.available_in = 2'($urandom_range(3));
        it.failed_in = 2'($urandom_range(3));
        it.clear_all = ($urandom_range(3) == 0);
        return it;
    endfunction

    typedef struct {
        lrdc_pkg::t_in_item  item;
        bit                  has_fixed;
        lrdc_pkg::t_out_item fixed;
    } t_stim_row;

    initial begin
        t_stim_row directed[$];
        t_stim_row row;
        logic [15:0] delays[5];
        int phase;
        row_fail_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_receiver = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        night_pool = '{64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0190_0000_0000, 64'd77};
        tag_pool = '{64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hDEAD_BEEF_0000_0001, 64'd5};
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: fixed results only where obvious.
        row = '{default: '0};
        row.has_fixed = 1'b1;
        row.item.op = lrdc_pkg::OP_TAKE_NEXT;    // empty queue after reset
        directed.push_back(row);
        row.item.op = lrdc_pkg::OP_COMPLETE;     // complete while idle
        row.item.failed_in = 2'b11;
        directed.push_back(row);
        row.item = '0;
        row.item.op = lrdc_pkg::OP_REQUEST;      // zero key is unavailable
        row.item.tag = 64'd9;
        row.fixed.request_status = lrdc_pkg::ST_UNAVAILABLE;
        directed.push_back(row);
        row.item.night_start = 64'd9;
        row.item.tag = '0;
        directed.push_back(row);
        row.has_fixed = 1'b0;
        for (int i = 0; i < 9; i++) begin        // fill the queue past full
            row.item = '0;
            row.item.op = lrdc_pkg::OP_REQUEST;
            row.item.night_start = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd100 + 64'(i);
            row.item.tag = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd1;
            row.item.req_mask = 2'b11;
            directed.push_back(row);
        end
        row.item.night_start = 64'd102;          // duplicate in queue
        directed.push_back(row);
        row.item = '0;
        row.item.op = lrdc_pkg::OP_TAKE_NEXT;
        directed.push_back(row);
        directed.push_back(row);                 // take next while active
        row.item = '0;
        row.item.op = lrdc_pkg::OP_REQUEST;      // duplicate of the active key
        row.item.night_start = 64'hFFFF_FFFF_FFFF_FFFF;
        row.item.tag = 64'hFFFF_FFFF_FFFF_FFFF;
        row.item.req_mask = 2'b01;
        directed.push_back(row);
        row.item.op = lrdc_pkg::OP_COMPLETE;     // failed outcome near time wrap
        row.item.now_ms = 32'hFFFF_FF00;
        row.item.checked_in = 2'b11;
        row.item.failed_in = 2'b01;
        directed.push_back(row);
        row.item.op = lrdc_pkg::OP_REQUEST;      // failed before retry time
        directed.push_back(row);
        row.item.req_mask = 2'b00;               // empty mask skips the table
        directed.push_back(row);
        row.item.req_mask = 2'b10;               // checked, absent: missing
        directed.push_back(row);
        row.item.req_mask = 2'b01;               // retry time passed
        row.item.now_ms = 32'h0000_1000;
        directed.push_back(row);
        row.item = '0;
        row.item.op = lrdc_pkg::OP_INVALIDATE;
        row.item.night_start = 64'd103;
        directed.push_back(row);
        row.item.clear_all = 1'b1;
        directed.push_back(row);

        foreach (directed[k])
            send_item(directed[k].item, directed[k].has_fixed, directed[k].fixed);
        drain_and_idle();

        // Random phases; the retry delay changes between them, extremes included.
        delays = '{16'd0, 16'hFFFF, 16'd1, 16'd2000, 16'd3000};
        for (phase = 0; phase < 5; phase++) begin
            write_retry_delay(delays[phase]);
            case (phase)
                0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
                1: begin sender_idle_pct = 52; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 52; end
                3: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 10; end
            endcase
            for (int n = 0; n < 246; n++) begin
                if (phase == 4 && n == 20) begin
                    hold_receiver <= 1'b1;
                    @(posedge i_clk);
                    hold_receiver <= 1'b0;
                end
                if (phase == 2 && n == 120)
                    drain_and_idle();
                send_item(random_item($urandom_range(9) != 0), 1'b0, '0);
            end
            drain_and_idle();
        end

        if (fail_count == 0 && row_fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
src/lrdc_pkg.sv
src/lrdc_ctrl.sv
src/lrdc_dp.sv
src/load_request_dedup_and_outcome_cache.sv
sim/tb_load_request_dedup_and_outcome_cache.sv
